>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the effect engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> hw/rtl/tvfx_pkg.sv
// Package with types, constants and tables for the voice effect engine.
package tvfx_pkg;
	localparam int unsigned NumVoicesDef = 4;
	localparam int unsigned PeriodTableSizeDef = 37;
	localparam logic [11:0] PeriodMin = 12'd113;
	localparam logic [11:0] PeriodMax = 12'd856;
	localparam logic [6:0] VolumeMax = 7'd64;

	localparam logic OP_ROW = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [3:0] FX_ARP = 4'd0;
	localparam logic [3:0] FX_PORTA_UP = 4'd1;
	localparam logic [3:0] FX_PORTA_DN = 4'd2;
	localparam logic [3:0] FX_TONE = 4'd3;
	localparam logic [3:0] FX_VIB = 4'd4;
	localparam logic [3:0] FX_TONE_VOL = 4'd5;
	localparam logic [3:0] FX_VIB_VOL = 4'd6;
	localparam logic [3:0] FX_VOL_SLIDE = 4'd10;
	localparam logic [3:0] FX_POS_JUMP = 4'd11;
	localparam logic [3:0] FX_SET_VOL = 4'd12;
	localparam logic [3:0] FX_SET_SPEED = 4'd15;

	typedef struct packed {
		logic operation;
		logic [1:0] voice;
		logic [4:0] tick_count;
		logic [11:0] note_period;
		logic has_sample;
		logic [6:0] sample_volume;
		logic [3:0] effect_code;
		logic [7:0] effect_param;
	} item_in_t;

	typedef struct packed {
		logic [1:0] voice_out;
		logic [11:0] period_out;
		logic period_valid;
		logic [6:0] volume_out;
		logic volume_valid;
		logic restart_sample;
	} item_out_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_SEARCH, ST_EXEC, ST_OUT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic search;
		logic exec;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic search_done;
		logic need_search;
	} dp_stat_t;

	function automatic logic [11:0] period_lut(input logic [5:0] idx);
		logic [11:0] r;
		case (idx)
			6'd0: r = 12'd856;  6'd1: r = 12'd808;  6'd2: r = 12'd762;
			6'd3: r = 12'd720;  6'd4: r = 12'd678;  6'd5: r = 12'd640;
			6'd6: r = 12'd604;  6'd7: r = 12'd570;  6'd8: r = 12'd538;
			6'd9: r = 12'd508;  6'd10: r = 12'd480; 6'd11: r = 12'd453;
			6'd12: r = 12'd428; 6'd13: r = 12'd404; 6'd14: r = 12'd381;
			6'd15: r = 12'd360; 6'd16: r = 12'd339; 6'd17: r = 12'd320;
			6'd18: r = 12'd302; 6'd19: r = 12'd285; 6'd20: r = 12'd269;
			6'd21: r = 12'd254; 6'd22: r = 12'd240; 6'd23: r = 12'd226;
			6'd24: r = 12'd214; 6'd25: r = 12'd202; 6'd26: r = 12'd190;
			6'd27: r = 12'd180; 6'd28: r = 12'd170; 6'd29: r = 12'd160;
			6'd30: r = 12'd151; 6'd31: r = 12'd143; 6'd32: r = 12'd135;
			6'd33: r = 12'd127; 6'd34: r = 12'd120; 6'd35: r = 12'd113;
			default: r = 12'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] sine_lut(input logic [4:0] idx);
		logic [7:0] r;
		case (idx)
			5'd0: r = 8'd0;    5'd1: r = 8'd24;   5'd2: r = 8'd49;   5'd3: r = 8'd74;
			5'd4: r = 8'd97;   5'd5: r = 8'd120;  5'd6: r = 8'd141;  5'd7: r = 8'd161;
			5'd8: r = 8'd180;  5'd9: r = 8'd197;  5'd10: r = 8'd212; 5'd11: r = 8'd224;
			5'd12: r = 8'd235; 5'd13: r = 8'd244; 5'd14: r = 8'd250; 5'd15: r = 8'd253;
			5'd16: r = 8'd255; 5'd17: r = 8'd253; 5'd18: r = 8'd250; 5'd19: r = 8'd244;
			5'd20: r = 8'd235; 5'd21: r = 8'd224; 5'd22: r = 8'd212; 5'd23: r = 8'd197;
			5'd24: r = 8'd180; 5'd25: r = 8'd161; 5'd26: r = 8'd141; 5'd27: r = 8'd120;
			5'd28: r = 8'd97;  5'd29: r = 8'd74;  5'd30: r = 8'd49;  default: r = 8'd24;
		endcase
		return r;
	endfunction
endpackage

>>> hw/rtl/tvfx_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`include "assert_macros.svh"
module tvfx_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               out_free,
	input  tvfx_pkg::dp_stat_t stat,
	output tvfx_pkg::dp_cmd_t  cmd,
	output logic               busy
);
	import tvfx_pkg::*;

	ctrl_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_fire) state_d = ST_READ;
			ST_READ:   state_d = stat.need_search ? ST_SEARCH : ST_EXEC;
			ST_SEARCH: if (stat.search_done) state_d = ST_EXEC;
			ST_EXEC:   state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE:   begin
				busy = 1'b0;
				cmd.load = in_fire;
			end
			ST_SEARCH: cmd.search = 1'b1;
			ST_EXEC:   cmd.exec = 1'b1;
			ST_OUT:    cmd.emit = out_free;
			default:   cmd = '0;
		endcase
	end

	`ASSERT_IMPL(a_load_idle, clk, arst_n, cmd.load, state_q == ST_IDLE)
	`ASSERT_NEXT(a_exec_then_out, clk, arst_n, cmd.exec, state_q == ST_OUT)
	`ASSERT_IMPL(a_one_cmd, clk, arst_n, 1'b1, $onehot0(cmd))
endmodule

>>> hw/rtl/tvfx_dp.sv
// Datapath: per-voice state, table search and effect arithmetic.
`include "assert_macros.svh"
module tvfx_dp #(
	parameter int unsigned NUM_VOICES = tvfx_pkg::NumVoicesDef,
	parameter int unsigned PERIOD_TABLE_SIZE = tvfx_pkg::PeriodTableSizeDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tvfx_pkg::item_in_t  item,
	input  logic                v2_mode,
	input  tvfx_pkg::dp_cmd_t   cmd,
	output tvfx_pkg::dp_stat_t  stat,
	output tvfx_pkg::item_out_t result
);
	import tvfx_pkg::*;

	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int TW = $clog2(PERIOD_TABLE_SIZE + 1);

	logic [11:0] base_period_q [NUM_VOICES];
	logic [3:0]  stored_effect_q [NUM_VOICES];
	logic [7:0]  stored_param_q [NUM_VOICES];
	logic [6:0]  voice_volume_q [NUM_VOICES];
	logic [11:0] slide_target_q [NUM_VOICES];
	logic        slide_downward_q [NUM_VOICES];
	logic [7:0]  slide_speed_q [NUM_VOICES];
	logic [7:0]  wobble_phase_q [NUM_VOICES];
	logic [7:0]  wobble_speed_q [NUM_VOICES];

	item_in_t    it_q;
	logic        vok_q;
	logic [VW-1:0] vi_q;
	logic [11:0] bp_q;
	logic [3:0]  eff_q;
	logic [7:0]  par_q;
	logic [6:0]  vol_q;
	logic [11:0] tgt_q;
	logic        down_q;
	logic [7:0]  spd_q;
	logic [7:0]  ph_q;
	logic [7:0]  wsp_q;
	logic [TW-1:0] idx_q;
	logic        found_q;
	logic [11:0] arp_q;
	logic [3:0]  off_q;
	item_out_t   res_q;

	// Voice index of the incoming item and its range check.
	logic [VW-1:0] vin;
	logic          vin_ok;
	assign vin = VW'(item.voice);
	assign vin_ok = ({30'd0, item.voice} < NUM_VOICES);

	// Arpeggio phase from tick count (mod 3 over five bits).
	logic [1:0] phase_d;
	always_comb begin
		case (item.tick_count)
			5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27, 5'd30:
				phase_d = 2'd0;
			5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28, 5'd31:
				phase_d = 2'd1;
			default: phase_d = 2'd2;
		endcase
	end
	logic [1:0] phase_q;

	// Search is needed for an arpeggio tick with a nonzero phase.
	assign stat.need_search = vok_q && it_q.operation == OP_TICK && eff_q == FX_ARP
		&& par_q != 8'd0 && phase_q != 2'd0;

	// One table entry is compared per cycle.
	logic [11:0] tab_e;
	logic [TW-1:0] lim;
	assign tab_e = period_lut(6'(idx_q));
	assign lim = TW'(PERIOD_TABLE_SIZE) - TW'(off_q);
	assign stat.search_done = found_q || (idx_q >= lim) || (bp_q >= tab_e);

	// Capture the item and set up and step the table search.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q <= item;
			vok_q <= vin_ok;
			vi_q <= vin;
			phase_q <= phase_d;
		end
		if (stat.need_search && !cmd.search && !cmd.exec && !cmd.emit) begin
			idx_q <= '0;
			found_q <= 1'b0;
			off_q <= (phase_q == 2'd1) ? par_q[7:4] : par_q[3:0];
		end else if (cmd.search && !found_q) begin
			if (idx_q < lim && bp_q >= tab_e) begin
				found_q <= 1'b1;
				arp_q <= period_lut(6'(idx_q + TW'(off_q)));
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Working copy of the voice state, read in the cycle after load.
	logic rd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_q <= 1'b0;
		else rd_q <= cmd.load;
	end
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bp_q <= base_period_q[vin];
			eff_q <= stored_effect_q[vin];
			par_q <= stored_param_q[vin];
			vol_q <= voice_volume_q[vin];
			tgt_q <= slide_target_q[vin];
			down_q <= slide_downward_q[vin];
			spd_q <= slide_speed_q[vin];
			ph_q <= wobble_phase_q[vin];
			wsp_q <= wobble_speed_q[vin];
		end
	end

	// Effect arithmetic on the working copy.
	logic [11:0] n_bp, n_tgt, pout;
	logic [3:0]  n_eff;
	logic [7:0]  n_par, n_spd, n_ph, n_wsp, par_t, wsp_e;
	logic [6:0]  n_vol, vout, svol;
	logic        n_down, pval, vval, rst_s, slide;
	logic signed [14:0] p, dl, ps;
	logic [11:0] mul;
	logic [6:0]  vpar;
	logic signed [8:0] vs;
	always_comb begin
		n_bp = bp_q; n_eff = eff_q; n_par = par_q; n_vol = vol_q;
		n_tgt = tgt_q; n_down = down_q; n_spd = spd_q; n_ph = ph_q; n_wsp = wsp_q;
		pout = '0; pval = 1'b0; vout = '0; vval = 1'b0; rst_s = 1'b0; slide = 1'b0;
		p = 15'(bp_q); dl = '0; ps = '0; mul = '0; par_t = par_q; wsp_e = wsp_q;
		svol = (it_q.sample_volume > VolumeMax) ? VolumeMax : it_q.sample_volume;
		vpar = (it_q.effect_param > 8'(VolumeMax)) ? VolumeMax : it_q.effect_param[6:0];
		vs = '0;
		if (vok_q && it_q.operation == OP_ROW) begin
			n_eff = it_q.effect_code;
			n_par = it_q.effect_param;
			par_t = it_q.effect_param;
			if (it_q.has_sample) begin
				n_vol = svol; vout = svol; vval = 1'b1;
			end
			if (it_q.note_period != 12'd0) begin
				if (it_q.effect_code == FX_TONE || it_q.effect_code == FX_TONE_VOL) begin
					if (it_q.note_period < bp_q) begin
						n_down = 1'b1; n_tgt = it_q.note_period;
					end else if (it_q.note_period > bp_q) begin
						n_down = 1'b0; n_tgt = it_q.note_period;
					end else begin
						n_tgt = '0;
					end
				end else begin
					rst_s = 1'b1; n_ph = '0; n_bp = it_q.note_period;
					pout = it_q.note_period; pval = 1'b1;
				end
			end
			if (it_q.effect_code == FX_SET_VOL) begin
				vout = vpar; vval = 1'b1;
				if (v2_mode) n_vol = vpar;
			end
		end else if (vok_q) begin
			case (eff_q)
				FX_ARP: begin
					if (par_q == 8'd0 || phase_q == 2'd0) begin
						pout = bp_q; pval = 1'b1;
					end else begin
						pout = found_q ? arp_q : 12'd0; pval = found_q;
					end
				end
				FX_PORTA_UP: begin
					p = 15'(bp_q) - 15'(par_q);
					if (p < 15'sd113) p = 15'(PeriodMin);
					n_bp = 12'(p); pout = 12'(p); pval = 1'b1;
				end
				FX_PORTA_DN: begin
					p = 15'(bp_q) + 15'(par_q);
					if (p > 15'sd856) p = 15'(PeriodMax);
					n_bp = 12'(p); pout = 12'(p); pval = 1'b1;
				end
				FX_TONE, FX_TONE_VOL: begin
					if (eff_q == FX_TONE_VOL) slide = 1'b1;
					else if (par_q != 8'd0) begin
						n_spd = par_q; n_par = '0; par_t = '0;
					end
					if (tgt_q != 12'd0) begin
						// The slide may undershoot below zero; compare as signed.
						if (down_q) begin
							p = 15'(bp_q) - 15'(n_spd);
							if (p <= $signed(15'(tgt_q))) begin p = 15'(tgt_q); n_tgt = '0; end
						end else begin
							p = 15'(bp_q) + 15'(n_spd);
							if (p >= $signed(15'(tgt_q))) begin p = 15'(tgt_q); n_tgt = '0; end
						end
						n_bp = (p < 0) ? 12'd0 : (p > 15'sd4095) ? 12'hfff : 12'(p);
					end
					pout = n_bp; pval = 1'b1;
				end
				FX_VIB, FX_VIB_VOL: begin
					if (eff_q == FX_VIB_VOL) slide = 1'b1;
					else if (par_q != 8'd0) begin n_wsp = par_q; wsp_e = par_q; end
					mul = 12'(wsp_e[3:0] * sine_lut(ph_q[6:2]));
					dl = v2_mode ? 15'(mul >> 6) : 15'(mul >> 7);
					ps = ph_q[7] ? (15'(bp_q) - dl) : (15'(bp_q) + dl);
					pout = (ps < 0) ? 12'd0 : (ps > 15'sd4095) ? 12'hfff : 12'(ps);
					pval = 1'b1;
					n_ph = ph_q + (8'(wsp_e >> 2) & 8'd60);
				end
				FX_VOL_SLIDE: slide = 1'b1;
				default: ;
			endcase
			if (slide) begin
				if (par_t[7:4] != 4'd0) vs = 9'(vol_q) + 9'(par_t[7:4]);
				else vs = 9'(vol_q) - 9'(par_t[3:0]);
				n_vol = (vs < 0) ? 7'd0 : (vs > 9'sd64) ? VolumeMax : 7'(vs);
				vout = n_vol; vval = 1'b1;
			end
		end
	end

	// Write back the voice state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				base_period_q[i] <= '0; stored_effect_q[i] <= '0;
				stored_param_q[i] <= '0; voice_volume_q[i] <= '0;
				slide_target_q[i] <= '0; slide_downward_q[i] <= 1'b0;
				slide_speed_q[i] <= '0; wobble_phase_q[i] <= '0;
				wobble_speed_q[i] <= '0;
			end
		end else if (cmd.exec && vok_q) begin
			base_period_q[vi_q] <= n_bp; stored_effect_q[vi_q] <= n_eff;
			stored_param_q[vi_q] <= n_par; voice_volume_q[vi_q] <= n_vol;
			slide_target_q[vi_q] <= n_tgt; slide_downward_q[vi_q] <= n_down;
			slide_speed_q[vi_q] <= n_spd; wobble_phase_q[vi_q] <= n_ph;
			wobble_speed_q[vi_q] <= n_wsp;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q <= '{voice_out: it_q.voice, period_out: pout, period_valid: pval,
				volume_out: vout, volume_valid: vval, restart_sample: rst_s};
		end
	end
	assign result = res_q;

	`ASSERT_IMPL(a_found_bound, clk, arst_n, cmd.search && found_q, idx_q < lim)
	`ASSERT_NEXT(a_read_after_load, clk, arst_n, cmd.load, rd_q)
	`ASSERT_IMPL(a_vol_max, clk, arst_n, cmd.exec, n_vol <= VolumeMax)
endmodule

>>> hw/rtl/tracker_voice_effect_engine_core.sv
// Top level of the tracker voice effect engine.
// channel | direction | handshake     | payload
// in      | into core | in_valid/stall| item_in_t
// out     | from core | out_valid/stall| item_out_t
// cfg     | into core | valid/ready   | version_two_mode bit
// An item passes through the load, read, execute and output states; an
// arpeggio tick with a nonzero phase adds a search state that compares the
// table entries one at a time, through the single table comparator.
// Reset clears all voice state and the mode bit at once; no transfer is taken
// while reset is asserted.
// A stalled output holds the result and blocks the next item.
module tracker_voice_effect_engine_core #(
	parameter int unsigned NUM_VOICES = tvfx_pkg::NumVoicesDef,
	parameter int unsigned PERIOD_TABLE_SIZE = tvfx_pkg::PeriodTableSizeDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tvfx_pkg::item_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output tvfx_pkg::item_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);
	import tvfx_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     busy, mode_q, ov_q;

	assign in_stall = busy || !arst_n;
	assign cfg_ready = arst_n;

	// Mode register transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b0;
		else if (cfg_valid && cfg_ready) mode_q <= cfg_data;
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.exec) ov_q <= 1'b1;
		else if (cmd.emit) ov_q <= 1'b0;
	end
	assign out_valid = ov_q;

	tvfx_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_valid && !in_stall),
		.out_free(!out_stall), .stat(stat), .cmd(cmd), .busy(busy)
	);

	tvfx_dp #(.NUM_VOICES(NUM_VOICES), .PERIOD_TABLE_SIZE(PERIOD_TABLE_SIZE)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(in_data), .v2_mode(mode_q),
		.cmd(cmd), .stat(stat), .result(out_data)
	);
endmodule
